>>> design/base36_vigenere_cipher_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the base-36 Vigenere cipher
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BASE36_VIGENERE_CIPHER_MACROS_SVH
`define BASE36_VIGENERE_CIPHER_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define B36_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the cycle after it.
`define B36_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

>>> design/b36vig_pkg.sv
// ----------------------------------------------------------------------------
// Base-36 Vigenere cipher package
// Character constants, register indexes and the base-36 digit mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b36vig_pkg;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned DIGIT_W    = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_CHARS = 2'd0,
        CFG_KEY_LEN   = 2'd1,
        CFG_DIRECTION = 2'd2
    } t_cfg_idx;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [6:0] BASE36       = 7'd36;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CHAR_UP_A    = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;  // 'Z'
    localparam logic [7:0] CHAR_LO_A    = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LO_Z    = 8'h7A;  // 'z'
    localparam logic [7:0] CASE_GAP     = 8'h20;
    localparam logic [7:0] UPPER_OFFSET = 8'd55;  // 'A' - 10
    localparam logic [7:0] LOWER_OFFSET = 8'd87;  // 'a' - 10

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    // Maps a folded character to 0..35; anything else counts as zero.
    function automatic logic [DIGIT_W-1:0] to_digit36(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (is_digit(c)) begin
            v = c - CHAR_ZERO;
        end else if (is_upper(c)) begin
            v = c - UPPER_OFFSET;
        end
        return v[DIGIT_W-1:0];
    endfunction

endpackage

>>> design/base36_vigenere_cipher.sv
// An accepted input word passes the input register, then the result register.
// Throughput: one word per cycle; the input register and the result register
// each hold one word, so input stall rises only when both are full and the
// output is stalled. Reset is synchronous and active low: it empties both
// stages, clears the key position and sets key 0, length 1 and encryption.
// ----------------------------------------------------------------------------
// Base-36 Vigenere cipher
// Shifts alphanumeric characters by a repeating key modulo 36 and passes
// all other characters through, one word per cycle while the output does not stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "base36_vigenere_cipher_macros.svh"

module base36_vigenere_cipher #(
    parameter int KEY_CHARS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [b36vig_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [b36vig_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_in_char,
    input  logic                                i_string_start,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_out_char
);
    import b36vig_pkg::*;

    localparam int POS_W = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEY_CHARS);

    logic [7:0]       r_key [KEY_CHARS];
    logic [LEN_W-1:0] r_key_len;
    logic             r_direction;
    logic [POS_W-1:0] r_key_pos;

    logic             r_s1_valid;
    logic [7:0]       r_s1_char;
    logic [POS_W-1:0] r_s1_pos;
    logic             r_out_valid;
    logic [7:0]       r_out_char;

    logic             in_accept;
    logic             s1_move;
    logic [LEN_W-1:0] eff_len;
    logic [POS_W-1:0] pos_raw;
    logic [POS_W-1:0] pos_use;
    logic [POS_W-1:0] n_key_pos;
    logic             n_s1_valid;
    logic             n_out_valid;

    logic [7:0]         data_fold;
    logic               data_alnum;
    logic [DIGIT_W-1:0] key_val;
    logic [DIGIT_W-1:0] data_val;
    logic [6:0]         sum_raw;
    logic [6:0]         sum_mod;
    logic [7:0]         n_out_char;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_CHARS; i++) begin
                r_key[i] <= 8'd0;
            end
            r_key_len   <= LEN_W'(1);
            r_direction <= DIR_ENCRYPT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_CHARS: begin
                    for (int i = 0; i < KEY_CHARS; i++) begin
                        r_key[i] <= i_cfg_data[8*i +: 8];
                    end
                end
                CFG_KEY_LEN:   r_key_len   <= i_cfg_data[LEN_W-1:0];
                CFG_DIRECTION: r_direction <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register
    // is empty or is being taken.
    assign s1_move    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Key position: a length of zero acts as one, and a length above the key
    // width is clamped to it.
    always_comb begin
        if (r_key_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_key_len > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_key_len;
        end
        pos_raw = i_string_start ? '0 : r_key_pos;
        pos_use = (LEN_W'(pos_raw) >= eff_len) ? '0 : pos_raw;
        n_key_pos = ((LEN_W'(pos_use) + LEN_W'(1)) >= eff_len) ? '0 :
                    POS_W'(pos_use + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos <= '0;
        end else if (in_accept) begin
            r_key_pos <= n_key_pos;
        end
    end

    // Input register
    assign n_s1_valid = in_accept ? 1'b1 : (s1_move ? 1'b0 : r_s1_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_char <= i_in_char;
            r_s1_pos  <= pos_use;
        end
    end

    // Base-36 shift of the registered character
    always_comb begin
        data_fold  = fold_upper(r_s1_char);
        data_alnum = is_digit(data_fold) || is_upper(data_fold);
        key_val    = to_digit36(fold_upper(r_key[r_s1_pos]));
        data_val   = to_digit36(data_fold);
        if (r_direction == DIR_DECRYPT) begin
            sum_raw = 7'(data_val) + BASE36 - 7'(key_val);
        end else begin
            sum_raw = 7'(data_val) + 7'(key_val);
        end
        sum_mod = (sum_raw >= BASE36) ? sum_raw - BASE36 : sum_raw;
        if (!data_alnum) begin
            n_out_char = r_s1_char;
        end else if (sum_mod < 7'd10) begin
            n_out_char = 8'(sum_mod) + CHAR_ZERO;
        end else if (r_direction == DIR_DECRYPT) begin
            n_out_char = 8'(sum_mod) + LOWER_OFFSET;
        end else begin
            n_out_char = 8'(sum_mod) + UPPER_OFFSET;
        end
    end

    // Result register
    assign n_out_valid = s1_move ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_valid) begin
            r_out_char <= n_out_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;

    `B36_ASSERT(a_stall_only_when_full, !o_in_stall || (r_s1_valid && r_out_valid),
        "input stalled while a stage is free")
    `B36_ASSERT_NEXT(a_word_advances, r_s1_valid && s1_move, r_out_valid,
        "word lost between input and result register")
    `B36_ASSERT_NEXT(a_start_single_key,
        in_accept && i_string_start && (eff_len == LEN_W'(1)), r_key_pos == '0,
        "key position not restarted")
    `B36_ASSERT_NEXT(a_held_result, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_out_char), "stalled result changed")

endmodule

>>> test/tb_base36_vigenere_cipher.sv
// ----------------------------------------------------------------------------
// Testbench for the base-36 Vigenere cipher
// A short table of directed words covers the character boundaries, both
// directions, out-of-range key lengths, a shrunken key, non-alphanumeric key
// characters and the start flag. Random strings follow, under random key
// settings and random back-pressure. Every accepted result is compared with
// the table's expected character or one worked out by a cycle-free model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_base36_vigenere_cipher;

    import b36vig_pkg::*;

    localparam int RANDOM_CHARS = 1800;
    localparam int QUIET_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 20;
    localparam logic [6:0] NOT_ALNUM = BASE36;

    typedef struct {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [63:0] value;
        logic        first;
        logic        known;
        logic [7:0]  want;
    } t_step;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_KEY_CHARS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_in_char      = 8'h00;
    logic        i_string_start = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_char;

    // Typed expectation that travels alongside the word being offered.
    logic        tag_known = 1'b0;
    logic [7:0]  tag_want  = 8'h00;

    // Model state of the cipher.
    logic [63:0] pred_key = '0;
    logic [3:0]  pred_len = 4'd1;
    logic        pred_dir = DIR_ENCRYPT;
    logic [2:0]  pred_pos = 3'd0;

    logic [7:0]  out_chars_due[$];
    t_step       plan[$];

    int n_errors   = 0;
    int n_checked  = 0;
    int n_chars    = 0;
    int n_strings  = 0;
    int n_writes   = 0;
    int n_rand     = 0;
    int quiet_cycles = 0;

    base36_vigenere_cipher #(
        .KEY_CHARS(8)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_char     (i_in_char),
        .i_string_start(i_string_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Value of a letter or digit in base 36, either case; NOT_ALNUM otherwise.
    function automatic logic [6:0] b36_value(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return 7'(c - CHAR_ZERO);
        end
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            return 7'(c - UPPER_OFFSET);
        end
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            return 7'(c - LOWER_OFFSET);
        end
        return NOT_ALNUM;
    endfunction

    // Works out the output character and moves the key position on.
    function automatic logic [7:0] cipher_char(input logic [7:0] c, input logic first);
        logic [3:0] span;
        logic [2:0] pos;
        logic [6:0] dv;
        logic [6:0] kv;
        logic [6:0] sum;
        logic [7:0] res;
        span = (pred_len == 4'd0) ? 4'd1 : (pred_len > 4'd8) ? 4'd8 : pred_len;
        pos  = first ? 3'd0 : pred_pos;
        if ({1'b0, pos} >= span) begin
            pos = 3'd0;
        end
        res = c;
        dv  = b36_value(c);
        if (dv != NOT_ALNUM) begin
            kv = b36_value(pred_key[8*pos +: 8]);
            if (kv == NOT_ALNUM) begin
                kv = 7'd0;
            end
            sum = (pred_dir == DIR_DECRYPT) ? dv + BASE36 - kv : dv + kv;
            if (sum >= BASE36) begin
                sum = sum - BASE36;
            end
            if (sum < 7'd10) begin
                res = CHAR_ZERO + 8'(sum);
            end else begin
                res = 8'(sum) + ((pred_dir == DIR_DECRYPT) ? LOWER_OFFSET : UPPER_OFFSET);
            end
        end
        pred_pos = ({1'b0, pos} + 4'd1 >= span) ? 3'd0 : pos + 3'd1;
        return res;
    endfunction

    function automatic logic [7:0] pick_alnum();
        logic [6:0] v;
        v = 7'($urandom_range(0, 35));
        if (v < 7'd10) begin
            return CHAR_ZERO + 8'(v);
        end
        return 8'(v) + ($urandom_range(0, 1) ? UPPER_OFFSET : LOWER_OFFSET);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return pick_alnum();
        end
        if (r < 87) begin
            return 8'($urandom_range(8'h20, 8'h7E));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int idle_len(input logic calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic void add_char(input logic [7:0] c, input logic first,
                                     input logic known, input logic [7:0] want);
        t_step s;
        s.is_cfg = 1'b0;
        s.idx    = CFG_KEY_CHARS;
        s.value  = 64'(c);
        s.first  = first;
        s.known  = known;
        s.want   = want;
        plan.push_back(s);
    endfunction

    function automatic void add_write(input t_cfg_idx idx, input logic [63:0] value);
        t_step s;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.value  = value;
        s.first  = 1'b0;
        s.known  = 1'b0;
        s.want   = 8'h00;
        plan.push_back(s);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic first, input logic known,
                             input logic [7:0] want, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_char      <= c;
        i_string_start <= first;
        tag_known      <= known;
        tag_want       <= want;
        do @(posedge i_clk); while (o_in_stall);
        n_chars++;
        if (first) begin
            n_strings++;
        end
    endtask

    // Holds the sender back until every outstanding word has come out. The
    // first edge lets the scoreboard log a word accepted at the last edge.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (out_chars_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_KEY_CHARS: pred_key = value;
            CFG_KEY_LEN:   pred_len = value[3:0];
            CFG_DIRECTION: pred_dir = value[0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        n_writes++;
        @(posedge i_clk);
    endtask

    // Receiver: free-running stretches broken by stalls, mostly short.
    initial begin
        forever begin
            repeat ($urandom_range(1, 12) + (($urandom_range(0, 9) == 0) ? 150 : 0))
                @(posedge i_clk);
            i_out_stall <= 1'b1;
            repeat (($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(8, 40))
                @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        logic [7:0] due;
        logic [7:0] calc;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (out_chars_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected word, expected none, got %h",
                                 $time, o_out_char);
                    end
                end else begin
                    due = out_chars_due.pop_front();
                    n_checked++;
                    if (o_out_char !== due) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display("%0t: out_char mismatch, expected %h, got %h",
                                     $time, due, o_out_char);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                calc = cipher_char(i_in_char, i_string_start);
                out_chars_due.push_back(tag_known ? tag_want : calc);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int         nstr;
        int         slen;
        int         r;
        logic       calm;
        logic       first;
        logic [63:0] key;
        logic [3:0] len;

        // Reset state: a zero key leaves letters as upper case and digits as they are.
        add_char("a", 1'b1, 1'b1, "A");
        add_char("z", 1'b0, 1'b1, "Z");
        add_char("9", 1'b0, 1'b1, "9");
        add_char(8'h00, 1'b0, 1'b1, 8'h00);
        add_char(8'hFF, 1'b0, 1'b1, 8'hFF);
        add_char("/", 1'b0, 1'b1, "/");
        add_char("{", 1'b0, 1'b1, "{");
        // A key of non-alphanumeric bytes while decrypting gives lower case.
        add_write(CFG_KEY_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(CFG_DIRECTION, 64'(DIR_DECRYPT));
        add_char("Q", 1'b1, 1'b1, "q");
        add_char("7", 1'b0, 1'b1, "7");
        // Key "Z1b*9aK0" with an oversized length, which acts as eight.
        add_write(CFG_KEY_CHARS, 64'h304B_6139_2A62_315A);
        add_write(CFG_KEY_LEN, 64'd15);
        add_write(CFG_DIRECTION, 64'(DIR_ENCRYPT));
        add_char("z", 1'b1, 1'b1, "Y");
        add_char("0", 1'b0, 1'b1, "1");
        add_char("Z", 1'b0, 1'b1, "A");
        add_char("k", 1'b0, 1'b1, "K");
        add_char(" ", 1'b0, 1'b1, " ");
        add_char("M", 1'b0, 1'b0, 8'h00);
        add_char("5", 1'b0, 1'b0, 8'h00);
        // The key shrinks under a key position of seven, which falls back to zero.
        add_write(CFG_KEY_LEN, 64'd2);
        add_write(CFG_DIRECTION, 64'(DIR_DECRYPT));
        add_char("A", 1'b0, 1'b1, "b");
        add_char("0", 1'b0, 1'b1, "z");
        add_char("0", 1'b1, 1'b1, "1");
        // A length of zero behaves as a single key character.
        add_write(CFG_KEY_LEN, 64'd0);
        add_char("X", 1'b0, 1'b1, "y");
        add_char("x", 1'b0, 1'b1, "y");

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_drain();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_char(plan[i].value[7:0], plan[i].first, plan[i].known,
                          plan[i].want, idle_len(1'b0));
            end
        end

        while (n_rand < RANDOM_CHARS) begin
            wait_drain();
            if ($urandom_range(0, 7) == 0) begin
                key = {$urandom, $urandom};
            end else begin
                for (int b = 0; b < 8; b++) begin
                    key[8*b +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                               : pick_alnum();
                end
            end
            r = $urandom_range(0, 99);
            len = (r < 6) ? 4'd0 : (r < 14) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(1, 8));
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_KEY_CHARS, key);
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_KEY_LEN, 64'(len));
            end
            if ($urandom_range(0, 1) != 0) begin
                write_reg(CFG_DIRECTION,
                          64'($urandom_range(0, 1) ? DIR_DECRYPT : DIR_ENCRYPT));
            end
            calm = ($urandom_range(0, 3) == 0);
            nstr = $urandom_range(3, 10);
            for (int s = 0; s < nstr; s++) begin
                slen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
                for (int k = 0; k < slen; k++) begin
                    // The first string of a phase sometimes carries on from the last one.
                    if (k == 0) begin
                        first = !(s == 0 && $urandom_range(0, 4) == 0);
                    end else begin
                        first = ($urandom_range(0, 29) == 0);
                    end
                    send_char(pick_char(), first, 1'b0, 8'h00, idle_len(calm));
                    n_rand++;
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d characters in %0d strings across %0d register writes,",
                 n_chars, n_strings, n_writes);
        $display("both directions and out-of-range key lengths; %0d words compared.",
                 n_checked);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
